### rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [15:0] TERM_UNIT    = 16'h0000;

  localparam logic [CP_W-1:0] CP_MIN2     = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MIN4     = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_BMP_MAX  = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_SUPP_OFS = 21'h010000;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // what remains of the decoded codepoint in a command
  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_ONE  = 2'd1;
  localparam logic [1:0] EMIT_PAIR = 2'd2;
  localparam logic [1:0] EMIT_LOW  = 2'd3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } out_item_t;

  // one classified request: repl replacement units, then the codepoint,
  // then an optional terminator
  typedef struct packed {
    logic [2:0]      repl;
    logic [1:0]      emit;
    logic [CP_W-1:0] cp;
    logic            term;
    logic            last;
  } cmd_t;

endpackage

### rtl/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Decode front end: tracks the open UTF-8 sequence and turns each byte that
// yields code units or ends a string into a command for the unit emitter.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8u16_pkg::in_item_t in_data,
  input  logic                queue_full,
  output logic                push,
  output u8u16_pkg::cmd_t     push_data
);
  import u8u16_pkg::*;

  logic            append_terminator;
  logic [2:0]      expected_length;
  logic [1:0]      bytes_seen;
  logic [CP_W-1:0] partial_codepoint;

  logic [2:0]      expected_length_next;
  logic [1:0]      bytes_seen_next;
  logic [CP_W-1:0] partial_codepoint_next;

  logic [7:0]      b;
  logic            last;
  logic            cont;
  logic [2:0]      seen;
  logic [CP_W-1:0] cp;
  logic            ok;
  logic            lead_go;
  logic [2:0]      lead_len;
  logic [CP_W-1:0] lead_bits;
  logic            accept;
  cmd_t            cmd;

  assign b        = in_data.byte_in;
  assign last     = in_data.last_byte;
  assign cont     = (b[7:6] == 2'b10);
  assign seen     = {1'b0, bytes_seen} + 3'd1;
  assign cp       = {partial_codepoint[CP_W-7:0], b[5:0]};
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (expected_length)
      LEN_2:   ok = (cp >= CP_MIN2);
      LEN_3:   ok = (cp >= CP_MIN3) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
      default: ok = (cp >= CP_MIN4) && (cp <= CP_MAX);
    endcase
  end

  always_comb begin
    cmd                    = '0;
    cmd.last               = last;
    expected_length_next   = expected_length;
    bytes_seen_next        = bytes_seen;
    partial_codepoint_next = partial_codepoint;
    lead_go                = 1'b0;
    lead_len               = LEN_NONE;
    lead_bits              = '0;

    if (expected_length != LEN_NONE) begin
      if (cont) begin
        if (seen >= expected_length) begin
          if (ok) begin
            cmd.emit = (cp > CP_BMP_MAX) ? EMIT_PAIR : EMIT_ONE;
            cmd.cp   = cp;
          end else begin
            cmd.repl = expected_length;
          end
          expected_length_next   = LEN_NONE;
          bytes_seen_next        = '0;
          partial_codepoint_next = '0;
        end else if (last) begin
          cmd.repl = seen;
        end else begin
          bytes_seen_next        = seen[1:0];
          partial_codepoint_next = cp;
        end
      end else begin
        cmd.repl               = {1'b0, bytes_seen};
        expected_length_next   = LEN_NONE;
        bytes_seen_next        = '0;
        partial_codepoint_next = '0;
        lead_go                = 1'b1;
      end
    end else begin
      lead_go = 1'b1;
    end

    if (lead_go) begin
      if (!b[7]) begin
        cmd.emit = EMIT_ONE;
        cmd.cp   = {{(CP_W-8){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
        lead_len  = LEN_2;
        lead_bits = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        lead_len  = LEN_3;
        lead_bits = {{(CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        lead_len  = LEN_4;
        lead_bits = {{(CP_W-3){1'b0}}, b[2:0]};
      end else begin
        cmd.repl = cmd.repl + 3'd1;
      end
      if (lead_len != LEN_NONE) begin
        if (last) begin
          cmd.repl = cmd.repl + 3'd1;
        end else begin
          expected_length_next   = lead_len;
          bytes_seen_next        = 2'd1;
          partial_codepoint_next = lead_bits;
        end
      end
    end

    if (last) begin
      expected_length_next   = LEN_NONE;
      bytes_seen_next        = '0;
      partial_codepoint_next = '0;
      cmd.term               = append_terminator;
    end
  end

  assign push      = accept && ((cmd.repl != 3'd0) || (cmd.emit != EMIT_NONE) || cmd.term || last);
  assign push_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      append_terminator <= 1'b0;
      expected_length   <= LEN_NONE;
      bytes_seen        <= '0;
      partial_codepoint <= '0;
    end else begin
      if (cfg_wr_en) begin
        append_terminator <= cfg_wr_data;
      end
      if (accept) begin
        expected_length   <= expected_length_next;
        bytes_seen        <= bytes_seen_next;
        partial_codepoint <= partial_codepoint_next;
      end
    end
  end

endmodule

### rtl/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Small command FIFO between the decode front end and the unit emitter.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8u16_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output u8u16_pkg::cmd_t pop_data,
  output logic            empty
);
  import u8u16_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Unit emitter: expands each command into UTF-16 code units, one per
// cycle unless the output is stalled, into a registered output.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  u8u16_pkg::cmd_t      pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8u16_pkg::out_item_t out_data
);
  import u8u16_pkg::*;

  cmd_t            cur;
  logic            cur_valid;
  cmd_t            cur_next;
  logic [15:0]     unit;
  logic            done;
  logic            step;
  logic [CP_W-1:0] v;
  logic            load;

  assign v    = cur.cp - CP_SUPP_OFS;
  assign step = cur_valid && (!out_valid || out_ready);

  always_comb begin
    cur_next = cur;
    unit     = TERM_UNIT;
    if (cur.repl != 3'd0) begin
      unit          = REPL_UNIT;
      cur_next.repl = cur.repl - 3'd1;
    end else begin
      case (cur.emit)
        EMIT_ONE: begin
          unit          = cur.cp[15:0];
          cur_next.emit = EMIT_NONE;
        end
        EMIT_PAIR: begin
          unit          = HI_SURR_BASE + {6'd0, v[19:10]};
          cur_next.emit = EMIT_LOW;
        end
        EMIT_LOW: begin
          unit          = LO_SURR_BASE + {6'd0, v[9:0]};
          cur_next.emit = EMIT_NONE;
        end
        default: begin
          unit          = TERM_UNIT;
          cur_next.term = 1'b0;
        end
      endcase
    end
  end

  assign done = (cur_next.repl == 3'd0) && (cur_next.emit == EMIT_NONE) && !cur_next.term;
  assign load = !cur_valid || (step && done);
  assign pop  = load && !empty;

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.code_unit <= unit;
      out_data.last_unit <= done && cur.last;
    end
    if (pop) begin
      cur <= pop_data;
    end else if (step) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= !empty;
      end
    end
  end

endmodule

### rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 transcoder with U+FFFD replacement.
// ----------------------------------------------------------------------------
// One UTF-8 byte is taken per cycle while the queue has room. The front end
// decodes it at once and, if it yields code units or ends a string, writes
// a command into a four-entry queue; the emitter drains the queue at one
// code unit per cycle, unless the output stalls, into a registered output.
// Surrogate pairs yield two units and malformed input up to five
// (replacements plus terminator), as the queue fills and in_ready drops.
// append_terminator (cfg_wr_data at cfg_wr_en) adds a zero unit after the
// output of the last byte; write it only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u8u16_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8u16_pkg::out_item_t out_data
);
  import u8u16_pkg::*;

  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  cmd_t push_data;
  cmd_t pop_data;

  u8u16_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .queue_full  (queue_full),
    .push        (push),
    .push_data   (push_data)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (queue_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks for the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_wr_en,
  input logic                 cfg_wr_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input u8u16_pkg::out_item_t out_data
);
  import u8u16_pkg::*;

  logic term_shadow;
  logic hi_pending;
  logic out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_shadow <= 1'b0;
      hi_pending  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        term_shadow <= cfg_wr_data;
      end
      if (out_fire) begin
        hi_pending <= (out_data.code_unit[15:10] == 6'b110110);
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_low_follows_high: assert property (@(posedge clk) disable iff (rst)
    out_fire && hi_pending |-> out_data.code_unit[15:10] == 6'b110111)
    else $error("high surrogate not followed by low surrogate");

  a_high_not_last: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_data.code_unit[15:10] == 6'b110110 |-> !out_data.last_unit)
    else $error("string ends on a high surrogate");

  a_terminator: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_data.last_unit && term_shadow |-> out_data.code_unit == TERM_UNIT)
    else $error("missing zero terminator");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data)
);

### verif/utf8_to_utf16_transcoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// Self-checking bench for the streaming UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
// Byte requests are queued per phase and fed with random gaps. The sink
// stalls at random. Every accepted byte is decoded by a behavioral model in
// the bench, and the code units it yields are compared in order with the
// units leaving the block. The phases cover both terminator settings:
// directed boundary and malformed cases first, then random strings that are
// mostly well formed with overlong, surrogate, out-of-range, truncated and
// stray-byte sequences mixed in.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_tb;
  import u8u16_pkg::*;

  logic      clk;
  logic      rst         = 1'b1;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;

  utf8_to_utf16_transcoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // bench copy of the decoder state and register
  logic        term_en  = 1'b0;
  logic [2:0]  seq_len  = LEN_NONE;
  logic [1:0]  seq_seen = '0;
  logic [20:0] seq_cp   = '0;

  in_item_t    byte_queue[$];
  out_item_t   expected_units[$];
  logic [15:0] step_units[$];

  int  errors         = 0;
  int  bytes_accepted = 0;
  int  strings_closed = 0;
  int  units_checked  = 0;
  int  queued_bytes   = 0;
  bit  req_taken      = 0;
  bit  unit_taken     = 0;
  int  feed_gap       = 0;
  int  sink_stall     = 0;
  bit  feed_calm      = 0;
  bit  sink_calm      = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- decoder
  task automatic add_codepoint(input logic [20:0] cp);
    logic [20:0] v;
    if (cp > CP_BMP_MAX) begin
      v = cp - CP_SUPP_OFS;
      step_units.push_back(HI_SURR_BASE + {6'd0, v[19:10]});
      step_units.push_back(LO_SURR_BASE + {6'd0, v[9:0]});
    end else begin
      step_units.push_back(cp[15:0]);
    end
  endtask

  task automatic add_repl(input int count);
    for (int i = 0; i < count; i++) step_units.push_back(REPL_UNIT);
  endtask

  task automatic close_seq();
    seq_len  = LEN_NONE;
    seq_seen = '0;
    seq_cp   = '0;
  endtask

  task automatic decode_lead(input logic [7:0] b, input logic last);
    logic [2:0]  len;
    logic [20:0] bits;
    len  = LEN_NONE;
    bits = '0;
    if (b[7] == 1'b0) begin
      step_units.push_back({8'd0, b});
      return;
    end
    if (b[7:5] == 3'b110) begin
      len  = LEN_2;
      bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      len  = LEN_3;
      bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      len  = LEN_4;
      bits = {18'd0, b[2:0]};
    end
    if (len == LEN_NONE || last) begin
      add_repl(1);
      return;
    end
    seq_len  = len;
    seq_seen = 2'd1;
    seq_cp   = bits;
  endtask

  task automatic transcode_byte(input in_item_t req);
    logic [7:0]  b;
    logic [20:0] cp;
    logic [2:0]  seen;
    logic        ok;
    out_item_t   u;
    b = req.byte_in;
    step_units.delete();
    if (seq_len != LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        seen = {1'b0, seq_seen} + 3'd1;
        cp   = {seq_cp[14:0], b[5:0]};
        if (seen >= seq_len) begin
          case (seq_len)
            LEN_2:   ok = cp >= CP_MIN2;
            LEN_3:   ok = cp >= CP_MIN3 && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
            default: ok = cp >= CP_MIN4 && cp <= CP_MAX;
          endcase
          if (ok) add_codepoint(cp);
          else add_repl(int'(seq_len));
          close_seq();
        end else if (req.last_byte) begin
          add_repl(int'(seen));
          close_seq();
        end else begin
          seq_seen = seen[1:0];
          seq_cp   = cp;
        end
      end else begin
        add_repl(int'(seq_seen));
        close_seq();
        decode_lead(b, req.last_byte);
      end
    end else begin
      decode_lead(b, req.last_byte);
    end
    if (req.last_byte) begin
      close_seq();
      if (term_en) step_units.push_back(TERM_UNIT);
      strings_closed++;
    end
    foreach (step_units[i]) begin
      u.code_unit = step_units[i];
      u.last_unit = req.last_byte && (i == step_units.size() - 1);
      expected_units.push_back(u);
    end
  endtask

  // ---------------------------------------------------------------- handshakes
  function automatic int draw_idle(inout bit calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      transcode_byte(in_data);
      bytes_accepted++;
      req_taken = 1;
    end
    if (!rst && out_valid && out_ready) begin
      unit_taken = 1;
      units_checked++;
      if (expected_units.size() == 0) begin
        report_mismatch($sformatf("unexpected unit %h last %b",
                                  out_data.code_unit, out_data.last_unit));
      end else begin
        if (out_data.code_unit !== expected_units[0].code_unit)
          report_mismatch($sformatf("code_unit %h, expected %h",
                                    out_data.code_unit, expected_units[0].code_unit));
        if (out_data.last_unit !== expected_units[0].last_unit)
          report_mismatch($sformatf("last_unit %b on unit %h, expected %b",
                                    out_data.last_unit, expected_units[0].code_unit,
                                    expected_units[0].last_unit));
        void'(expected_units.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && !(in_valid && !req_taken)) begin
      req_taken = 0;
      if (feed_gap != 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_data  <= byte_queue.pop_front();
        in_valid <= 1'b1;
        feed_gap = draw_idle(feed_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (unit_taken) begin
      unit_taken = 0;
      sink_stall = draw_idle(sink_calm);
    end
    if (sink_stall != 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // queue the first keep bytes of cp encoded in len bytes, no range check
  task automatic push_seq(input logic [20:0] cp, input int len, input int keep,
                          input logic last);
    logic [7:0] enc[4];
    in_item_t   item;
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: enc[0] = {3'b110, cp[10:6]};
      3: enc[0] = {4'b1110, cp[15:12]};
      default: enc[0] = {5'b11110, cp[20:18]};
    endcase
    for (int i = 1; i < len; i++) enc[i] = {2'b10, 6'(cp >> (6 * (len - 1 - i)))};
    for (int i = 0; i < keep; i++) begin
      item.byte_in   = enc[i];
      item.last_byte = last && (i == keep - 1);
      byte_queue.push_back(item);
      queued_bytes++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    push_seq({13'd0, b}, 1, 1, last);
    byte_queue[$].byte_in = b;
  endtask

  task automatic push_random_string();
    int          nseq;
    int          kind;
    int          len;
    logic [20:0] cp;
    logic        last;
    nseq = $urandom_range(1, 5);
    for (int s = 0; s < nseq; s++) begin
      last = (s == nseq - 1);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = $urandom_range(1, 4);
        case (len)
          1: cp = 21'($urandom_range(0, 'h7F));
          2: cp = 21'($urandom_range('h80, 'h7FF));
          3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp ^= 21'h2000;
          end
          default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        push_seq(cp, len, len, last);
      end else if (kind < 68) begin
        len = $urandom_range(2, 4);
        cp  = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
              (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                           21'($urandom_range(0, 'hFFFF));
        push_seq(cp, len, len, last);
      end else if (kind < 73) begin
        push_seq(21'($urandom_range('hD800, 'hDFFF)), 3, 3, last);
      end else if (kind < 78) begin
        push_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4, last);
      end else if (kind < 86) begin
        len = $urandom_range(2, 4);
        push_seq(21'($urandom_range(0, 'h1FFFFF)), len, $urandom_range(1, len - 1), last);
      end else if (kind < 93) begin
        push_byte(8'($urandom_range(0, 255)), last);
      end else if (kind < 97) begin
        push_byte(8'($urandom_range('h80, 'hBF)), last);
      end else begin
        push_byte(8'($urandom_range('hF8, 'hFF)), last);
      end
    end
  endtask

  task automatic push_random_phase(input int count);
    int stop_at;
    stop_at = queued_bytes + count;
    while (queued_bytes < stop_at) push_random_string();
  endtask

  task automatic set_terminator(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    term_en = v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_units.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    set_terminator(1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_seq(21'h80, 2, 2, 1'b0);
    push_seq(21'hFFFF, 3, 3, 1'b0);
    push_seq(21'h10FFFF, 4, 4, 1'b1);
    push_byte(8'h80, 1'b0);             // stray continuation
    push_byte(8'hFF, 1'b0);             // invalid lead
    push_byte(8'hC3, 1'b0);             // bad continuation, then ASCII
    push_byte(8'h41, 1'b0);
    push_seq(21'h0, 2, 2, 1'b0);        // overlong
    push_seq(21'hD800, 3, 3, 1'b0);     // encoded surrogate
    push_seq(21'h110000, 4, 4, 1'b0);   // above U+10FFFF
    push_seq(21'h20AC, 3, 2, 1'b1);     // truncated by the last mark
    push_byte(8'hC3, 1'b1);             // multi-byte lead marked last
    drain();

    set_terminator(1'b0);
    push_random_phase(30);
    drain();
    set_terminator(1'b1);
    push_random_phase(30);
    drain();
    set_terminator(1'b0);
    push_random_phase(30);
    drain();

    $display("Run covered %0d bytes in %0d strings, %0d code units checked,",
             bytes_accepted, strings_closed, units_checked);
    $display("with the terminator both on and off.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder.sv
rtl/u8u16_checker.sv
verif/utf8_to_utf16_transcoder_tb.sv
